/* rtl/core/wmh_pkg.sv */
package wmh_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned NumWords = 16;

    typedef logic [WordW-1:0] word_t;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_256 = 2'd1;
    localparam logic [1:0] KEY_512 = 2'd2;

    localparam logic [1:0] CFG_KEY_SIZE = 2'd0;
    localparam logic [1:0] CFG_SALT_EN  = 2'd1;
    localparam logic [1:0] CFG_SALT_TIME = 2'd2;

    localparam word_t INIT_CHAIN [NumWords] = '{
        32'd1415926535, 32'd897932384, 32'd4264338327, 32'd2884197169,
        32'd3993751058, 32'd2097494459, 32'd2307816406, 32'd2862089986,
        32'd2803482534, 32'd2117067982, 32'd1480865132, 32'd823066470,
        32'd3844609550, 32'd582231725, 32'd3594081284, 32'd811174502
    };

    function automatic word_t rotl(input word_t v, input logic [4:0] n);
        word_t r;
        r = (n == 5'd0) ? v : ((v << n) | (v >> (6'd32 - {1'b0, n})));
        return r;
    endfunction

    function automatic word_t rotr(input word_t v, input logic [4:0] n);
        word_t r;
        r = (n == 5'd0) ? v : ((v >> n) | (v << (6'd32 - {1'b0, n})));
        return r;
    endfunction

    function automatic word_t lnot(input word_t x);
        word_t r;
        r = (x == '0) ? 32'd1 : 32'd0;
        return r;
    endfunction

    typedef struct packed {
        logic    ready;
        logic [4:0] s11;
        logic [4:0] s13;
        logic [4:0] s17;
        logic [4:0] s19;
    } salt_ctl_t;

endpackage

/* rtl/core/word_mix_hash_digest.sv */
// word_mix_hash_digest: one packed word per transaction, sixteen words per block.
// Words before the sixteenth are packed and stored; the sixteenth word runs the mix
// step sequencer for 16 steps of OPA, MUL and ACC (one shared 32x32 multiplier).
// Digest: 4, 8 or 16 words, one per cycle, after the mix or after an early final word.
// Reset: asynchronous active low; chaining state to constants, count to zero.
// The receiver cannot stall: each digest word is valid for one cycle only.
module word_mix_hash_digest
    import wmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  byte_zero,
    input  logic [7:0]  byte_one,
    input  logic [7:0]  byte_two,
    input  logic [7:0]  byte_three,
    input  logic        message_end,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        digest_valid,
    output logic [31:0] digest_word,
    output logic        digest_last
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PACK = 6'b000010,
        S_OPA  = 6'b000100,
        S_MUL  = 6'b001000,
        S_ACC  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t     state_reg;
    logic [1:0] key_reg;
    logic       salt_en_reg;
    salt_ctl_t  sctl;

    word_t      blk_reg [NumWords];
    word_t      h_reg   [NumWords];
    logic [3:0] cnt_reg;
    logic [3:0] step_reg;
    logic       end_reg;
    logic [7:0] b0_reg, b1_reg, b2_reg, b3_reg;
    word_t      opa_reg, opb_reg, add_reg, prod_reg;
    logic       use_mul_reg;
    logic [3:0] oidx_reg;
    logic [4:0] on_reg;

    // salted shift residues recompute on every salt_time write;
    // busy is held high until they are ready
    wmh_salt_mod u_salt (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cfg_we && cfg_index == CFG_SALT_TIME),
        .value (cfg_data),
        .ctl   (sctl)
    );

    // pack the four bytes into one word
    word_t pk;
    always_comb
    begin
        word_t w0, w1, w2, w3;
        logic [4:0] a0, a1, a2, a3, c0, c1, c2, c3;
        if (salt_en_reg)
        begin
            a0 = sctl.s11; a2 = sctl.s19; a1 = sctl.s13; a3 = sctl.s17;
            c3 = sctl.s17; c0 = sctl.s11; c2 = sctl.s19; c1 = sctl.s13;
        end
        else
        begin
            a0 = 5'd11; a2 = 5'd7; a1 = 5'd13; a3 = 5'd11;
            c3 = 5'd17; c0 = 5'd13; c2 = 5'd19; c1 = 5'd17;
        end
        w0 = (word_t'(b0_reg) << a0) + (word_t'(b2_reg) << a2);
        w1 = (word_t'(b1_reg) << a1) + (word_t'(b3_reg) << a3);
        w2 = (word_t'(b3_reg) << c3) + (word_t'(b0_reg) << c0);
        w3 = (word_t'(b2_reg) << c2) + (word_t'(b1_reg) << c1);
        pk = rotl(w0, 5'd24) + rotl(w1, 5'd16) + rotl(w2, 5'd8) + w3;
    end

    // operand selection for mix step k: value = h[k] + add + (mul ? a*b : 0)
    word_t sa, sb, sadd;
    logic  smul;
    always_comb
    begin
        word_t m [NumWords];
        word_t h [NumWords];
        m = blk_reg;
        h = h_reg;
        sa = '0; sb = '0; sadd = '0; smul = 1'b0;
        unique case (step_reg)
            4'd0:  begin sa = rotl(h[0], m[0][4:0]); sb = m[0]; smul = 1'b1; end
            4'd1:  begin sa = m[1] ^ h[0]; sb = h[0]; smul = 1'b1; end
            4'd2:  sadd = (h[0] & m[2]) + h[1];
            4'd3:  sadd = ((h[1] ^ h[2]) | m[3]) - h[2];
            4'd4:  sadd = rotl(h[3] & m[4], h[4][4:0]) + h[3];
            4'd5:  sadd = rotr(m[5], h[4][4:0]) + h[4];
            4'd6:  begin sa = lnot(m[6]) ^ h[5]; sb = h[5]; smul = 1'b1; end
            4'd7:  sadd = rotr(h[6] ^ h[5], m[7][4:0]) + h[6];
            4'd8:  sadd = rotl(h[5] + m[8], h[3][4:0]) - h[7];
            4'd9:  begin sa = m[9] ^ lnot(h[7]); sb = h[8]; smul = 1'b1; end
            4'd10: sadd = ((h[7] + m[10]) - h[8]) & h[9];
            4'd11: sadd = rotr(m[11], h[3][4:0]) + h[10];
            4'd12: begin sa = m[12] + h[2]; sb = h[11]; smul = 1'b1; end
            4'd13: sadd = (m[13] & h[1]) - lnot(h[12]);
            4'd14: sadd = (h[12] ^ h[0]) + m[14];
            4'd15: begin sa = h[13] - m[15]; sb = h[14] ^ h[12]; smul = 1'b1; end
            default: ;
        endcase
    end

    // digest word selection
    word_t dsel;
    always_comb
    begin
        unique case (key_reg)
            KEY_128:
            begin
                unique case (oidx_reg[1:0])
                    2'd0: dsel = (h_reg[0] & h_reg[8]) + (h_reg[4] ^ h_reg[12]);
                    2'd1: dsel = prod_reg;
                    2'd2: dsel = (h_reg[2] ^ h_reg[10]) + (h_reg[6] & h_reg[14]);
                    default: dsel = prod_reg;
                endcase
            end
            KEY_256: dsel = h_reg[{1'b0, oidx_reg[2:0]}] + h_reg[{1'b1, oidx_reg[2:0]}];
            default: dsel = h_reg[oidx_reg];
        endcase
    end

    // 128-bit product words, precomputed ahead through operand and product registers
    logic [1:0] nidx;
    word_t fa, fb;
    assign nidx = oidx_reg[1:0] + 2'd1;
    always_comb
    begin
        if (nidx == 2'd1)
        begin
            fa = h_reg[1] + h_reg[9]; fb = h_reg[5] - h_reg[13];
        end
        else
        begin
            fa = h_reg[3] - h_reg[11]; fb = h_reg[7] + h_reg[15];
        end
    end

    word_t mul_full;
    assign mul_full = opa_reg * opb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            key_reg <= KEY_512;
            salt_en_reg <= 1'b0;
            cnt_reg <= '0;
            step_reg <= '0;
            end_reg <= 1'b0;
            oidx_reg <= '0;
            on_reg <= '0;
            use_mul_reg <= 1'b0;
            for (int i = 0; i < NumWords; i++) h_reg[i] <= INIT_CHAIN[i];
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_SIZE:  key_reg <= cfg_data[1:0];
                    CFG_SALT_EN:   salt_en_reg <= cfg_data[0];
                    CFG_SALT_TIME: ;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && !busy)
                    begin
                        b0_reg <= byte_zero; b1_reg <= byte_one;
                        b2_reg <= byte_two;  b3_reg <= byte_three;
                        end_reg <= message_end;
                        state_reg <= S_PACK;
                    end
                end
                S_PACK:
                begin
                    blk_reg[cnt_reg] <= pk;
                    if (cnt_reg == 4'd15)
                    begin
                        cnt_reg <= '0;
                        step_reg <= '0;
                        state_reg <= S_OPA;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                        state_reg <= end_reg ? S_OUT : S_IDLE;
                    end
                    if (end_reg && cnt_reg != 4'd15)
                    begin
                        oidx_reg <= '0;
                        on_reg <= (key_reg == KEY_128) ? 5'd4 :
                                  (key_reg == KEY_256) ? 5'd8 : 5'd16;
                        opa_reg <= h_reg[1] + h_reg[9];
                        opb_reg <= h_reg[5] - h_reg[13];
                        cnt_reg <= '0;
                    end
                end
                S_OPA:
                begin
                    opa_reg <= sa; opb_reg <= sb;
                    add_reg <= sadd; use_mul_reg <= smul;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg <= mul_full;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    h_reg[step_reg] <= h_reg[step_reg]
                        + (use_mul_reg ? prod_reg : add_reg);
                    if (step_reg == 4'd15)
                    begin
                        if (end_reg)
                        begin
                            state_reg <= S_OUT;
                            oidx_reg <= '0;
                            on_reg <= (key_reg == KEY_128) ? 5'd4 :
                                      (key_reg == KEY_256) ? 5'd8 : 5'd16;
                            // words 1, 5, 9 and 13 are final by the last step
                            opa_reg <= h_reg[1] + h_reg[9];
                            opb_reg <= h_reg[5] - h_reg[13];
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                        state_reg <= S_OPA;
                    end
                end
                S_OUT:
                begin
                    // prepare product for the next 128-bit word (registered multiplier)
                    prod_reg <= mul_full;
                    opa_reg <= fa; opb_reg <= fb;
                    if ({1'b0, oidx_reg} == on_reg - 5'd1)
                    begin
                        state_reg <= S_IDLE;
                        for (int i = 0; i < NumWords; i++) h_reg[i] <= INIT_CHAIN[i];
                    end
                    else
                        oidx_reg <= oidx_reg + 4'd1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE) || !sctl.ready;
    assign digest_valid = (state_reg == S_OUT);
    assign digest_word = dsel;
    assign digest_last = (state_reg == S_OUT) && ({1'b0, oidx_reg} == on_reg - 5'd1);

    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> busy)
        else $error("digest while idle");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        digest_last |=> !digest_valid)
        else $error("digest after last");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> busy)
        else $error("accept during mix");
endmodule

/* rtl/core/wmh_salt_mod.sv */
module wmh_salt_mod
    import wmh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  word_t     value,
    output salt_ctl_t ctl
);
    // residues of the salt value, registered per step: weight the bytes by 2^8k mod m,
    // fold the sum once more, then reduce with constant compare-subtract steps
    logic [1:0]  stage_reg;
    logic [13:0] sum11_reg, sum13_reg, sum17_reg, sum19_reg;
    logic [8:0]  fold11_reg, fold13_reg, fold17_reg, fold19_reg;
    logic [4:0]  r11_reg, r13_reg, r17_reg, r19_reg;

    function automatic logic [13:0] byte_fold(input word_t v, input logic [4:0] w1,
                                              input logic [4:0] w2, input logic [4:0] w3);
        logic [13:0] s;
        s = 14'(v[7:0]) + 14'(v[15:8]) * 14'(w1)
          + 14'(v[23:16]) * 14'(w2) + 14'(v[31:24]) * 14'(w3);
        return s;
    endfunction

    function automatic logic [8:0] fold_again(input logic [13:0] s, input logic [4:0] w1);
        logic [8:0] t;
        t = 9'(s[7:0]) + 9'(s[13:8]) * 9'(w1);
        return t;
    endfunction

    function automatic logic [4:0] reduce(input logic [8:0] t, input logic [4:0] m);
        logic [8:0] r;
        r = t;
        for (int k = 4; k >= 0; k--)
        begin
            if (r >= (9'(m) << k)) r = r - (9'(m) << k);
        end
        return r[4:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            sum11_reg <= '0; sum13_reg <= '0; sum17_reg <= '0; sum19_reg <= '0;
            fold11_reg <= '0; fold13_reg <= '0; fold17_reg <= '0; fold19_reg <= '0;
            r11_reg <= '0; r13_reg <= '0; r17_reg <= '0; r19_reg <= '0;
        end
        else if (load)
        begin
            // byte weights: 256, 65536 and 2^24 taken mod each modulus
            sum11_reg <= byte_fold(value, 5'd3, 5'd9, 5'd5);
            sum13_reg <= byte_fold(value, 5'd9, 5'd3, 5'd1);
            sum17_reg <= byte_fold(value, 5'd1, 5'd1, 5'd1);
            sum19_reg <= byte_fold(value, 5'd9, 5'd5, 5'd7);
            stage_reg <= 2'b01;
        end
        else if (stage_reg[0])
        begin
            fold11_reg <= fold_again(sum11_reg, 5'd3);
            fold13_reg <= fold_again(sum13_reg, 5'd9);
            fold17_reg <= fold_again(sum17_reg, 5'd1);
            fold19_reg <= fold_again(sum19_reg, 5'd9);
            stage_reg <= 2'b10;
        end
        else if (stage_reg[1])
        begin
            r11_reg <= reduce(fold11_reg, 5'd11);
            r13_reg <= reduce(fold13_reg, 5'd13);
            r17_reg <= reduce(fold17_reg, 5'd17);
            r19_reg <= reduce(fold19_reg, 5'd19);
            stage_reg <= 2'b00;
        end
    end

    assign ctl.ready = (stage_reg == 2'b00);
    assign ctl.s11 = r11_reg;
    assign ctl.s13 = r13_reg;
    assign ctl.s17 = r17_reg;
    assign ctl.s19 = r19_reg;
endmodule
